### rtl/core/mixed_group_knapsack_unit_macros.svh
// Assertion macros shared by the mixed group knapsack unit.
// Included by the sequencer, which checks its own sequencing; no other dependencies.
`ifndef MIXED_GROUP_KNAPSACK_UNIT_MACROS_SVH
`define MIXED_GROUP_KNAPSACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MGK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mgk: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MGK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mgk: next-cycle check failed");

`endif

### rtl/core/mgk_pkg.sv
// Package for the mixed group knapsack unit: widths, command and mode codes,
// sweep control types and the saturating value helpers. No dependencies.
package mgk_pkg;

   localparam int MAX_BUDGET_DEF = 127;

   localparam int CMD_W    = 2;
   localparam int MODE_W   = 2;
   localparam int COST_W   = 7;
   localparam int GAIN_W   = 16;
   localparam int VAL_W    = 32;
   localparam int BUDGET_W = 7;

   localparam logic [CMD_W-1:0] CMD_OPEN   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ITEM   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

   localparam logic [MODE_W-1:0] MODE_AT_LEAST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_AT_MOST  = 2'd1;

   localparam logic [VAL_W-1:0] UNREACHED  = '1;
   localparam logic [VAL_W-1:0] ZERO_VALUE = '0;
   localparam logic [VAL_W-1:0] VALUE_TOP  = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_OPEN,
      OP_ITEM,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   last;
   } ctl_type;

   // Reachable entries are never negative, so the sum fits in 32 bits unsigned.
   function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0]  base,
                                                input logic [GAIN_W-1:0] gain);
      logic [VAL_W-1:0] sum;
      sum = base + VAL_W'(gain);
      if (base == UNREACHED) begin
         sat_add = UNREACHED;
      end else if (sum[VAL_W-1]) begin
         sat_add = VALUE_TOP;
      end else begin
         sat_add = sum;
      end
   endfunction

   function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
      smax = ($signed(a) > $signed(b)) ? a : b;
   endfunction

endpackage

### rtl/core/mgk_row_store.sv
// Row store: the finished row and the working row, one entry per spent budget.
// Depends on mgk_pkg. One write address, registered read data.
module mgk_row_store #(
   parameter int  MAX_BUDGET = mgk_pkg::MAX_BUDGET_DEF,
   localparam int AW         = $clog2(MAX_BUDGET + 1)
) (
   input  logic                      clock,
   input  logic [AW-1:0]             rd_k_addr,
   input  logic [AW-1:0]             rd_src_addr,
   output logic [mgk_pkg::VAL_W-1:0] cur_k_data_ff,
   output logic [mgk_pkg::VAL_W-1:0] cur_src_data_ff,
   output logic [mgk_pkg::VAL_W-1:0] prev_src_data_ff,
   input  logic [AW-1:0]             wr_addr,
   input  logic                      cur_we,
   input  logic                      prev_we,
   input  logic [mgk_pkg::VAL_W-1:0] cur_wdata,
   input  logic [mgk_pkg::VAL_W-1:0] prev_wdata
);
   import mgk_pkg::*;

   localparam int DEPTH = MAX_BUDGET + 1;

   logic [VAL_W-1:0] cur_row_mem  [DEPTH];
   logic [VAL_W-1:0] prev_row_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_row_mem[wr_addr] <= cur_wdata;
      end
      cur_k_data_ff   <= cur_row_mem[rd_k_addr];
      cur_src_data_ff <= cur_row_mem[rd_src_addr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_row_mem[wr_addr] <= prev_wdata;
      end
      prev_src_data_ff <= prev_row_mem[rd_src_addr];
   end

endmodule

### rtl/core/mgk_update_unit.sv
// Shared update unit: saturating adds and maximum for one budget cell per cycle,
// the row write-back values and the running best. Depends on mgk_pkg.
module mgk_update_unit #(
   parameter int  MAX_BUDGET = mgk_pkg::MAX_BUDGET_DEF,
   localparam int AW         = $clog2(MAX_BUDGET + 1)
) (
   input  logic                       clock,
   input  mgk_pkg::ctl_type           ctl1,
   input  mgk_pkg::ctl_type           ctl2,
   input  logic [AW-1:0]              wr_addr,
   input  logic [AW-1:0]              limit,
   input  logic [mgk_pkg::MODE_W-1:0] active_mode,
   input  logic                       commit_sel,
   input  logic [mgk_pkg::GAIN_W-1:0] item_value,
   input  logic                       best_clear,
   input  logic [mgk_pkg::VAL_W-1:0]  cur_k_data,
   input  logic [mgk_pkg::VAL_W-1:0]  cur_src_data,
   input  logic [mgk_pkg::VAL_W-1:0]  prev_src_data,
   output logic                       cur_we,
   output logic                       prev_we,
   output logic [mgk_pkg::VAL_W-1:0]  cur_wdata,
   output logic [mgk_pkg::VAL_W-1:0]  prev_wdata,
   output logic [mgk_pkg::VAL_W-1:0]  best_value
);
   import mgk_pkg::*;

   logic [VAL_W-1:0] cand_ff;
   logic [VAL_W-1:0] cand_in;
   logic [VAL_W-1:0] old_ff;
   logic [VAL_W-1:0] best_ff;
   logic [VAL_W-1:0] best_in;
   logic [VAL_W-1:0] gain_cur;
   logic [VAL_W-1:0] gain_prev;

   always_comb begin
      gain_cur  = (active_mode != MODE_AT_MOST) ? sat_add(cur_src_data, item_value)
                                                : UNREACHED;
      gain_prev = sat_add(prev_src_data, item_value);
      if (ctl1.op == OP_ITEM) begin
         cand_in = smax(gain_cur, gain_prev);
      end else begin
         cand_in = commit_sel ? cur_src_data : prev_src_data;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      old_ff  <= cur_k_data;
      best_ff <= best_in;
   end

   always_comb begin
      cur_we     = 1'b0;
      prev_we    = 1'b0;
      cur_wdata  = cand_ff;
      prev_wdata = cand_ff;
      if (ctl2.valid) begin
         case (ctl2.op)
            OP_ITEM: begin
               cur_we    = 1'b1;
               cur_wdata = smax(cand_ff, old_ff);
            end
            OP_OPEN: begin
               prev_we    = 1'b1;
               cur_we     = 1'b1;
               prev_wdata = cand_ff;
               cur_wdata  = (active_mode == MODE_AT_LEAST) ? UNREACHED : cand_ff;
            end
            default: begin
               prev_we    = 1'b1;
               cur_we     = 1'b1;
               prev_wdata = (wr_addr == '0) ? ZERO_VALUE : UNREACHED;
               cur_wdata  = UNREACHED;
            end
         endcase
      end
   end

   always_comb begin
      best_in = best_ff;
      if (best_clear) begin
         best_in = UNREACHED;
      end else if (ctl2.valid && ctl2.op == OP_FINISH && wr_addr <= limit &&
                   $signed(cand_ff) > $signed(best_ff)) begin
         best_in = cand_ff;
      end
   end

   assign best_value = best_ff;

endmodule

### rtl/core/mgk_sequencer.sv
// Sequencer: decodes items, walks the budget cells of a sweep and tracks the
// group state. Depends on mgk_pkg and the assertion macro header.
`include "mixed_group_knapsack_unit_macros.svh"

module mgk_sequencer #(
   parameter int  MAX_BUDGET = mgk_pkg::MAX_BUDGET_DEF,
   localparam int AW         = $clog2(MAX_BUDGET + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mgk_pkg::CMD_W-1:0]    req_command,
   input  logic [mgk_pkg::MODE_W-1:0]   req_group_mode,
   input  logic [mgk_pkg::COST_W-1:0]   req_item_cost,
   input  logic [mgk_pkg::GAIN_W-1:0]   req_item_value,
   input  logic [mgk_pkg::BUDGET_W-1:0] budget,
   input  logic                         out_free,
   output logic                         emit,
   output logic                         best_clear,
   output logic [AW-1:0]                rd_k_addr,
   output logic [AW-1:0]                rd_src_addr,
   output mgk_pkg::ctl_type             ctl1,
   output mgk_pkg::ctl_type             ctl2,
   output logic [AW-1:0]                wr_addr,
   output logic [AW-1:0]                limit,
   output logic [mgk_pkg::MODE_W-1:0]   active_mode,
   output logic                         commit_sel,
   output logic [mgk_pkg::GAIN_W-1:0]   item_value
);
   import mgk_pkg::*;

   localparam int BW = (AW > COST_W) ? AW : COST_W;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [AW-1:0]     k_ff, k_in;
   logic [AW-1:0]     cost_ff, cost_in;
   logic [GAIN_W-1:0] value_ff, value_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              group_open_ff, group_open_in;
   logic              commit_ff, commit_in;
   ctl_type           ctl1_ff, ctl1_in;
   ctl_type           ctl2_ff;
   logic [AW-1:0]     k1_ff;
   logic [AW-1:0]     k2_ff;
   logic [BW-1:0]     budget_ext;
   logic [BW-1:0]     cost_ext;
   logic              cost_over;
   logic              sweep_last;

   always_comb begin
      budget_ext = BW'(budget);
      cost_ext   = BW'(req_item_cost);
      limit      = (budget_ext < BW'(MAX_BUDGET)) ? budget_ext[AW-1:0] : AW'(MAX_BUDGET);
      cost_over  = cost_ext > BW'(limit);
      sweep_last = (op_ff == OP_ITEM) ? (k_ff == cost_ff) : (k_ff == AW'(MAX_BUDGET));
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      k_in          = k_ff;
      cost_in       = cost_ff;
      value_in      = value_ff;
      mode_in       = mode_ff;
      group_open_in = group_open_ff;
      commit_in     = commit_ff;
      ctl1_in       = '0;
      req_ready     = (state_ff == ST_IDLE);
      emit          = 1'b0;
      best_clear    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_OPEN: begin
                     commit_in     = group_open_ff;
                     group_open_in = 1'b1;
                     mode_in       = req_group_mode;
                     op_in         = OP_OPEN;
                     k_in          = '0;
                     state_in      = ST_SWEEP;
                  end
                  CMD_ITEM: begin
                     if (group_open_ff && !cost_over) begin
                        op_in    = OP_ITEM;
                        k_in     = limit;
                        cost_in  = cost_ext[AW-1:0];
                        value_in = req_item_value;
                        state_in = ST_SWEEP;
                     end
                  end
                  CMD_FINISH: begin
                     commit_in     = group_open_ff;
                     group_open_in = 1'b0;
                     mode_in       = MODE_AT_LEAST;
                     op_in         = OP_FINISH;
                     k_in          = '0;
                     best_clear    = 1'b1;
                     state_in      = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            ctl1_in.valid = 1'b1;
            ctl1_in.op    = op_ff;
            ctl1_in.last  = sweep_last;
            if (sweep_last) begin
               state_in = ST_DRAIN;
            end else if (op_ff == OP_ITEM) begin
               k_in = k_ff - AW'(1);
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!ctl1_ff.valid && !ctl2_ff.valid) begin
               state_in = (op_ff == OP_FINISH) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         op_ff         <= OP_CLEAR;
         k_ff          <= '0;
         mode_ff       <= MODE_AT_LEAST;
         group_open_ff <= 1'b0;
         commit_ff     <= 1'b0;
         ctl1_ff       <= '0;
         ctl2_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         k_ff          <= k_in;
         mode_ff       <= mode_in;
         group_open_ff <= group_open_in;
         commit_ff     <= commit_in;
         ctl1_ff       <= ctl1_in;
         ctl2_ff       <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      cost_ff  <= cost_in;
      value_ff <= value_in;
      k1_ff    <= k_ff;
      k2_ff    <= k1_ff;
   end

   assign rd_k_addr   = k_ff;
   assign rd_src_addr = (op_ff == OP_ITEM) ? k_ff - cost_ff : k_ff;
   assign ctl1        = ctl1_ff;
   assign ctl2        = ctl2_ff;
   assign wr_addr     = k2_ff;
   assign active_mode = mode_ff;
   assign commit_sel  = commit_ff;
   assign item_value  = value_ff;

   `MGK_ASSERT_NOW(a_item_sweep_above_cost, clock, reset,
      state_ff == ST_SWEEP && op_ff == OP_ITEM, k_ff >= cost_ff)
   `MGK_ASSERT_NEXT(a_nothing_after_last, clock, reset,
      ctl1_ff.valid && ctl1_ff.last, !ctl1_ff.valid)
   `MGK_ASSERT_NOW(a_ready_when_drained, clock, reset,
      req_ready, !ctl1_ff.valid && !ctl2_ff.valid)

endmodule

### rtl/core/mixed_group_knapsack_unit.sv
// Each open, add or finish item sweeps the row store, one budget cell per cycle through the
// shared update unit: open and finish items cover cells 0 to MAX_BUDGET, an add item the
// cells from limit down to its cost. A finish item waits while the previous result waits;
// ignored items start no sweep. One item is worked on at a time. A finish result lands in
// the output register once its sweep has drained and that register is free. Synchronous
// active-high reset starts a row clearing pass with req_ready low and the budget set to zero.
module mixed_group_knapsack_unit #(
   parameter int MAX_BUDGET = mgk_pkg::MAX_BUDGET_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mgk_pkg::CMD_W-1:0]           req_command,
   input  logic [mgk_pkg::MODE_W-1:0]          req_group_mode,
   input  logic [mgk_pkg::COST_W-1:0]          req_item_cost,
   input  logic [mgk_pkg::GAIN_W-1:0]          req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mgk_pkg::VAL_W-1:0]    rsp_best_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mgk_pkg::BUDGET_W-1:0]        csr_budget
);
   import mgk_pkg::*;

   localparam int AW = $clog2(MAX_BUDGET + 1);

   logic [BUDGET_W-1:0]      budget_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_best_value_ff;
   logic                     out_free;
   logic                     emit;
   logic                     best_clear;
   logic [AW-1:0]            rd_k_addr;
   logic [AW-1:0]            rd_src_addr;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            limit;
   ctl_type                  ctl1;
   ctl_type                  ctl2;
   logic [MODE_W-1:0]        active_mode;
   logic                     commit_sel;
   logic [GAIN_W-1:0]        item_value;
   logic [VAL_W-1:0]         cur_k_data;
   logic [VAL_W-1:0]         cur_src_data;
   logic [VAL_W-1:0]         prev_src_data;
   logic                     cur_we;
   logic                     prev_we;
   logic [VAL_W-1:0]         cur_wdata;
   logic [VAL_W-1:0]         prev_wdata;
   logic [VAL_W-1:0]         best_value;

   mgk_sequencer #(.MAX_BUDGET(MAX_BUDGET)) u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_group_mode (req_group_mode),
      .req_item_cost  (req_item_cost),
      .req_item_value (req_item_value),
      .budget         (budget_ff),
      .out_free       (out_free),
      .emit           (emit),
      .best_clear     (best_clear),
      .rd_k_addr      (rd_k_addr),
      .rd_src_addr    (rd_src_addr),
      .ctl1           (ctl1),
      .ctl2           (ctl2),
      .wr_addr        (wr_addr),
      .limit          (limit),
      .active_mode    (active_mode),
      .commit_sel     (commit_sel),
      .item_value     (item_value)
   );

   mgk_row_store #(.MAX_BUDGET(MAX_BUDGET)) u_row_store (
      .clock            (clock),
      .rd_k_addr        (rd_k_addr),
      .rd_src_addr      (rd_src_addr),
      .cur_k_data_ff    (cur_k_data),
      .cur_src_data_ff  (cur_src_data),
      .prev_src_data_ff (prev_src_data),
      .wr_addr          (wr_addr),
      .cur_we           (cur_we),
      .prev_we          (prev_we),
      .cur_wdata        (cur_wdata),
      .prev_wdata       (prev_wdata)
   );

   mgk_update_unit #(.MAX_BUDGET(MAX_BUDGET)) u_update_unit (
      .clock         (clock),
      .ctl1          (ctl1),
      .ctl2          (ctl2),
      .wr_addr       (wr_addr),
      .limit         (limit),
      .active_mode   (active_mode),
      .commit_sel    (commit_sel),
      .item_value    (item_value),
      .best_clear    (best_clear),
      .cur_k_data    (cur_k_data),
      .cur_src_data  (cur_src_data),
      .prev_src_data (prev_src_data),
      .cur_we        (cur_we),
      .prev_we       (prev_we),
      .cur_wdata     (cur_wdata),
      .prev_wdata    (prev_wdata),
      .best_value    (best_value)
   );

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            budget_ff <= csr_budget;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_best_value_ff <= $signed(best_value);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_value = rsp_best_value_ff;

endmodule
